// File: rtl/rwu_pkg.sv
// Shared types and constants for the RPROP weight update block.
// Used by the front end, queue, back end and top level; depends on nothing else.
`default_nettype none

package rwu_pkg;

  localparam int NUM_PARAMS = 4096;
  localparam int IDX_W      = $clog2(NUM_PARAMS);
  localparam int IN_IDX_W   = 12;
  localparam int VAL_W      = 32;
  localparam int STEP_W     = 31;
  localparam int FAC_W      = 16;
  localparam int PROD_W     = STEP_W + FAC_W;
  localparam int FRAC_W     = 14;
  localparam int SIGN_W     = 2;
  localparam int STATE_W    = STEP_W + SIGN_W;
  localparam int CFG_IDX_W  = 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [FAC_W-1:0]  INC_RESET       = FAC_W'(19661);
  localparam logic [FAC_W-1:0]  DEC_RESET       = FAC_W'(8192);
  localparam logic [STEP_W-1:0] STEP_MAX_RESET  = STEP_W'(3276800);
  localparam logic [STEP_W-1:0] STEP_INIT_RESET = STEP_W'(4588);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_INC_FACTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEC_FACTOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_MAX   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_INIT  = 2'd3;

  // Sign codes as kept in the state memory; the fourth code reads as zero.
  localparam logic [SIGN_W-1:0] SGN_ZERO = 2'd0;
  localparam logic [SIGN_W-1:0] SGN_POS  = 2'd1;
  localparam logic [SIGN_W-1:0] SGN_NEG  = 2'd2;

  typedef enum logic [1:0] {
    SC_AGREE = 2'd0,
    SC_FLIP  = 2'd1,
    SC_ZERO  = 2'd2
  } rwu_scase_t;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_INIT   = 2'd1,
    OP_FROZEN = 2'd2
  } rwu_op_t;

  typedef struct packed {
    logic [FAC_W-1:0]  inc_factor;
    logic [FAC_W-1:0]  dec_factor;
    logic [STEP_W-1:0] step_max;
    logic [STEP_W-1:0] step_init;
  } rwu_cfg_t;

  // One classified request as it waits in the queue.
  typedef struct packed {
    rwu_op_t           op;
    logic [IDX_W-1:0]  idx;
    logic [SIGN_W-1:0] gsign;
    logic [VAL_W-1:0]  wval;
    logic              zero_val;
  } rwu_item_t;

endpackage

`default_nettype wire

// File: rtl/rwu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rwu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/rwu_front.sv
// Front end: takes input requests and classifies them into queue entries.
// Depends on rwu_pkg.
`default_nettype none

module rwu_front
  import rwu_pkg::*;
(
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    in_cmd,
  input  wire logic [IN_IDX_W-1:0]     in_param_index,
  input  wire logic signed [VAL_W-1:0] in_gradient,
  input  wire logic signed [VAL_W-1:0] in_weight_value,
  input  wire logic                    in_is_bias,
  input  wire logic                    in_frozen,
  input  wire logic                    in_enabled,
  input  wire logic                    queue_full,
  output logic                         push,
  output rwu_item_t                    push_item
);

  logic [SIGN_W-1:0] gsign;

  always_comb begin
    if (in_gradient == '0) begin
      gsign = SGN_ZERO;
    end else if (in_gradient[VAL_W-1]) begin
      gsign = SGN_NEG;
    end else begin
      gsign = SGN_POS;
    end
  end

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  always_comb begin
    push_item.idx   = in_param_index[IDX_W-1:0];
    push_item.gsign = gsign;
    push_item.wval  = in_weight_value;
    priority if (in_cmd) begin
      push_item.op       = OP_INIT;
      push_item.zero_val = 1'b0;
    end else if (in_frozen) begin
      // A frozen bias is still masked by the enable flag; a frozen weight is not.
      push_item.op       = OP_FROZEN;
      push_item.zero_val = in_is_bias && !in_enabled;
    end else begin
      push_item.op       = OP_UPDATE;
      push_item.zero_val = !in_enabled;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rwu_queue.sv
// Short request queue between the front end and the back end.
// Depends on rwu_pkg.
`default_nettype none

module rwu_queue
  import rwu_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  rwu_item_t push_item,
  input  wire logic pop,
  output logic      full,
  output logic      not_empty,
  output rwu_item_t head
);

  rwu_item_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rwu_back.sv
// Back end: reads per-entry state, updates step and sign, moves the value.
// Depends on rwu_pkg and rwu_ram.
`default_nettype none

module rwu_back
  import rwu_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  rwu_cfg_t                      cfg,
  input  wire logic                     q_not_empty,
  input  rwu_item_t                     q_head,
  output logic                          pop,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [VAL_W-1:0]       out_new_value,
  output logic        [STEP_W-1:0]      out_step_size,
  output logic        [1:0]             out_sign_case
);

  // Stage 1: state lookup and step update.
  logic        s1_valid_r, s1_valid_nxt;
  rwu_item_t   s1_item_r;
  logic        s1_adv, s1_free;

  // Stage 2: value update.
  logic              s2_valid_r, s2_valid_nxt;
  rwu_op_t           s2_op_r;
  logic [STEP_W-1:0] s2_step_r;
  rwu_scase_t        s2_scase_r;
  logic [SIGN_W-1:0] s2_gsign_r;
  logic [VAL_W-1:0]  s2_wval_r;
  logic              s2_zero_r;
  logic              s2_adv;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]  out_value_r;
  logic [STEP_W-1:0] out_step_r;
  rwu_scase_t        out_scase_r;

  // Most recent state write, used to bypass the memory read.
  logic              lw_valid_r;
  logic [IDX_W-1:0]  lw_idx_r;
  logic [STATE_W-1:0] lw_state_r;

  logic               ram_we;
  logic [STATE_W-1:0] ram_wdata;
  logic [STATE_W-1:0] ram_rdata;
  logic [STATE_W-1:0] cur_state;
  logic [STEP_W-1:0]  cur_step;
  logic [SIGN_W-1:0]  cur_sign;
  logic [FAC_W-1:0]   factor;
  logic [PROD_W-1:0]  prod;
  logic [STEP_W+1:0]  scaled;
  logic               scale_en;
  logic [STEP_W-1:0]  step_nxt;
  rwu_scase_t         scase_nxt;

  logic signed [VAL_W+1:0] sum;
  logic [VAL_W-1:0]        value_nxt;

  assign out_valid     = out_valid_r;
  assign out_new_value = out_value_r;
  assign out_step_size = out_step_r;
  assign out_sign_case = out_scase_r;

  // Handshake chain from the output register back to the queue.
  assign s2_adv  = s2_valid_r && (!out_valid_r || !out_stall);
  assign s1_adv  = s1_valid_r && (!s2_valid_r || s2_adv);
  assign s1_free = !s1_valid_r || s1_adv;
  assign pop     = q_not_empty && s1_free;

  always_comb begin
    s1_valid_nxt  = s1_free ? q_not_empty : s1_valid_r;
    s2_valid_nxt  = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_r);
    out_valid_nxt = s2_adv ? 1'b1 : ((out_valid_r && !out_stall) ? 1'b0 : out_valid_r);
  end

  rwu_ram #(
    .WIDTH (STATE_W),
    .DEPTH (NUM_PARAMS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_item_r.idx),
    .wdata (ram_wdata),
    .re    (pop),
    .raddr (q_head.idx),
    .rdata (ram_rdata)
  );

  // The last write to an index is always the current content of that entry,
  // so a match may be taken from the bypass register whether or not the
  // memory read already saw it.
  assign cur_state = (lw_valid_r && lw_idx_r == s1_item_r.idx) ? lw_state_r : ram_rdata;
  assign cur_step  = cur_state[STEP_W-1:0];
  assign cur_sign  = cur_state[STATE_W-1:STEP_W];

  always_comb begin
    scale_en = (cur_sign == SGN_POS || cur_sign == SGN_NEG) && (s1_item_r.gsign != SGN_ZERO);
    factor   = (cur_sign == s1_item_r.gsign) ? cfg.inc_factor : cfg.dec_factor;
    prod     = PROD_W'(cur_step) * PROD_W'(factor);
    scaled   = scale_en ? prod[PROD_W-1:FRAC_W] : {2'b00, cur_step};
    unique case (s1_item_r.op)
      OP_INIT: begin
        step_nxt  = cfg.step_init;
        scase_nxt = SC_ZERO;
        ram_wdata = {SGN_ZERO, cfg.step_init};
      end
      OP_FROZEN: begin
        step_nxt  = cur_step;
        scase_nxt = SC_ZERO;
        ram_wdata = cur_state;
      end
      default: begin
        step_nxt  = (scaled > {2'b00, cfg.step_max}) ? cfg.step_max : scaled[STEP_W-1:0];
        scase_nxt = !scale_en ? SC_ZERO :
                    ((cur_sign == s1_item_r.gsign) ? SC_AGREE : SC_FLIP);
        ram_wdata = {s1_item_r.gsign, step_nxt};
      end
    endcase
  end

  assign ram_we = s1_adv && (s1_item_r.op != OP_FROZEN);

  // Exact sum in 34 bits, then clamp to the signed 32-bit range.
  always_comb begin
    sum = {{2{s2_wval_r[VAL_W-1]}}, s2_wval_r};
    if (s2_op_r == OP_UPDATE && s2_gsign_r == SGN_POS) begin
      sum = sum + $signed({3'b000, s2_step_r});
    end else if (s2_op_r == OP_UPDATE && s2_gsign_r == SGN_NEG) begin
      sum = sum - $signed({3'b000, s2_step_r});
    end
    priority if (s2_zero_r) begin
      value_nxt = '0;
    end else if (sum[VAL_W+1:VAL_W-1] == 3'b000 || sum[VAL_W+1:VAL_W-1] == 3'b111) begin
      value_nxt = sum[VAL_W-1:0];
    end else if (sum[VAL_W+1]) begin
      value_nxt = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      value_nxt = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      lw_valid_r  <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (ram_we) begin
        lw_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_item_r <= q_head;
    end
    if (ram_we) begin
      lw_idx_r   <= s1_item_r.idx;
      lw_state_r <= ram_wdata;
    end
    if (s1_adv) begin
      s2_op_r    <= s1_item_r.op;
      s2_step_r  <= step_nxt;
      s2_scase_r <= scase_nxt;
      s2_gsign_r <= s1_item_r.gsign;
      s2_wval_r  <= s1_item_r.wval;
      s2_zero_r  <= s1_item_r.zero_val;
    end
    if (s2_adv) begin
      out_value_r <= value_nxt;
      out_step_r  <= s2_step_r;
      out_scase_r <= s2_scase_r;
    end
  end

  a_bypass_tracks_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> lw_valid_r && lw_idx_r == $past(s1_item_r.idx))
    else $error("bypass register does not hold the last state write");

  a_update_step_capped: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && s2_op_r == OP_UPDATE |-> s2_step_r <= cfg.step_max)
    else $error("updated step exceeds the configured maximum");

  a_init_step: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && s2_op_r == OP_INIT |-> s2_step_r == cfg.step_init && s2_scase_r == SC_ZERO)
    else $error("init request did not report the initial step");

  a_scase_only_update: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && s2_scase_r != SC_ZERO |-> s2_op_r == OP_UPDATE)
    else $error("sign agreement reported for a request that is not an update");

endmodule

`default_nettype wire

// File: rtl/rprop_weight_update.sv
// RPROP per-parameter weight update, top level.
// Holds the configuration registers; depends on rwu_pkg, rwu_front,
// rwu_queue and rwu_back.
//
// Usage:
//   Each input request names one weight or bias entry and carries its
//   gradient and current value. A request is taken at a rising edge with
//   in_valid high and in_stall low; a result is taken at an edge with
//   out_valid high and out_stall low. Every request yields one result, in
//   order.
//   Throughput is one request per cycle while out_stall is low, also when
//   consecutive requests hit the same entry: the step update (state read,
//   one 31x16 multiply, cap against step_max) closes in the state/step
//   stage, with the last state write bypassed around the state memory.
//   A taken request passes through the queue, the state/step stage, the
//   value stage and the output register before its result is presented.
//   A four-entry queue separates the front end from the update pipeline.
//   When out_stall is high the output register holds its result, the
//   pipeline behind it holds, the queue fills, and in_stall rises once it
//   is full.
//   Reset loads the default factors and step limits and empties the queue
//   and pipeline. The per-entry state memory is not cleared: an entry must
//   get an init request before its first update or frozen request.
//   Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once
//   and are meant for times when no request is in flight.
`default_nettype none

module rprop_weight_update
  import rwu_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic                    in_cmd,
  input  wire logic [IN_IDX_W-1:0]     in_param_index,
  input  wire logic signed [VAL_W-1:0] in_gradient,
  input  wire logic signed [VAL_W-1:0] in_weight_value,
  input  wire logic                    in_is_bias,
  input  wire logic                    in_frozen,
  input  wire logic                    in_enabled,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [VAL_W-1:0]      out_new_value,
  output logic        [STEP_W-1:0]     out_step_size,
  output logic        [1:0]            out_sign_case,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [STEP_W-1:0]       cfg_wdata
);

  rwu_cfg_t  cfg_r, cfg_nxt;
  logic      queue_full;
  logic      queue_not_empty;
  logic      push;
  logic      pop;
  rwu_item_t push_item;
  rwu_item_t head_item;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_INC_FACTOR: cfg_nxt.inc_factor = cfg_wdata[FAC_W-1:0];
        CFG_DEC_FACTOR: cfg_nxt.dec_factor = cfg_wdata[FAC_W-1:0];
        CFG_STEP_MAX:   cfg_nxt.step_max   = cfg_wdata;
        CFG_STEP_INIT:  cfg_nxt.step_init  = cfg_wdata;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inc_factor <= INC_RESET;
      cfg_r.dec_factor <= DEC_RESET;
      cfg_r.step_max   <= STEP_MAX_RESET;
      cfg_r.step_init  <= STEP_INIT_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rwu_front u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_param_index  (in_param_index),
    .in_gradient     (in_gradient),
    .in_weight_value (in_weight_value),
    .in_is_bias      (in_is_bias),
    .in_frozen       (in_frozen),
    .in_enabled      (in_enabled),
    .queue_full      (queue_full),
    .push            (push),
    .push_item       (push_item)
  );

  rwu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .head      (head_item)
  );

  rwu_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_not_empty   (queue_not_empty),
    .q_head        (head_item),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_new_value (out_new_value),
    .out_step_size (out_step_size),
    .out_sign_case (out_sign_case)
  );

endmodule

`default_nettype wire

// File: tb/tb_rprop_weight_update.sv
`timescale 1ns / 1ps
// Self-checking testbench for rprop_weight_update: directed and random requests,
// checked against an in-bench RPROP predictor across several register settings.
// Depends on rwu_pkg and the rprop_weight_update RTL.

module tb_rprop_weight_update;
  import rwu_pkg::*;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_INIT   = 1'b1;
  localparam int   IDLE_PCT   = 26;
  localparam int   HOLD_LEN   = 60;
  localparam int   HOLD_AT    = 150;
  localparam logic signed [VAL_W+1:0] VAL_HI = 34'sd2147483647;
  localparam logic signed [VAL_W+1:0] VAL_LO = -34'sd2147483648;

  typedef struct packed {
    logic                cmd;
    logic [IN_IDX_W-1:0] idx;
    logic [VAL_W-1:0]    grad;
    logic [VAL_W-1:0]    wval;
    logic                is_bias;
    logic                frozen;
    logic                enabled;
  } param_req_t;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [STEP_W-1:0] step;
    rwu_scase_t        scase;
  } param_res_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    in_cmd = CMD_UPDATE;
  logic [IN_IDX_W-1:0]     in_param_index = '0;
  logic signed [VAL_W-1:0] in_gradient = '0;
  logic signed [VAL_W-1:0] in_weight_value = '0;
  logic                    in_is_bias = 1'b0;
  logic                    in_frozen = 1'b0;
  logic                    in_enabled = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [VAL_W-1:0] out_new_value;
  logic [STEP_W-1:0]       out_step_size;
  logic [1:0]              out_sign_case;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = CFG_INC_FACTOR;
  logic [STEP_W-1:0]       cfg_wdata = '0;

  rprop_weight_update dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_param_index  (in_param_index),
    .in_gradient     (in_gradient),
    .in_weight_value (in_weight_value),
    .in_is_bias      (in_is_bias),
    .in_frozen       (in_frozen),
    .in_enabled      (in_enabled),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_new_value   (out_new_value),
    .out_step_size   (out_step_size),
    .out_sign_case   (out_sign_case),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // Predictor state: registers, per-entry step and sign, and which entries
  // the stimulus has already initialized.
  logic [FAC_W-1:0]  m_inc       = INC_RESET;
  logic [FAC_W-1:0]  m_dec       = DEC_RESET;
  logic [STEP_W-1:0] m_step_max  = STEP_MAX_RESET;
  logic [STEP_W-1:0] m_step_init = STEP_INIT_RESET;
  logic [STEP_W-1:0] step_mem [NUM_PARAMS];
  logic [SIGN_W-1:0] sign_mem [NUM_PARAMS];
  bit                entry_ready [NUM_PARAMS];

  param_req_t req_backlog[$];
  param_res_t results_due[$];
  param_req_t cur_req;

  int n_sent = 0;
  int n_results = 0;
  int n_errors = 0;
  int n_agree = 0;
  int n_flip = 0;
  int n_zero = 0;
  int n_phases = 0;
  bit hold_on = 1'b0;
  bit calm;

  // A stretch of requests where neither side idles.
  assign calm = (n_sent >= 300) && (n_sent < 420);

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

  // One long receiver hold while the sender keeps offering requests.
  initial begin : hold_off
    wait (rst_n);
    wait (n_results >= HOLD_AT);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    hold_on <= 1'b0;
  end

  task automatic flag_error(input string msg);
    if (n_errors < 40) $display("ERROR at %0t: %s", $time, msg);
    n_errors++;
  endtask

  function automatic param_res_t rprop_predict(input param_req_t r);
    param_res_t            res;
    logic [SIGN_W-1:0]     ps;
    logic [SIGN_W-1:0]     gs;
    logic [PROD_W-1:0]     s;
    logic signed [VAL_W+1:0] nv;
    res.value = r.wval;
    res.scase = SC_ZERO;
    if (r.cmd == CMD_INIT) begin
      step_mem[r.idx] = m_step_init;
      sign_mem[r.idx] = SGN_ZERO;
      res.step = m_step_init;
    end else if (r.frozen) begin
      res.step = step_mem[r.idx];
      if (r.is_bias && !r.enabled) res.value = '0;
    end else begin
      ps = sign_mem[r.idx];
      gs = (r.grad == '0) ? SGN_ZERO : (r.grad[VAL_W-1] ? SGN_NEG : SGN_POS);
      s = PROD_W'(step_mem[r.idx]);
      if (ps != SGN_ZERO && gs != SGN_ZERO) begin
        if (ps == gs) begin
          s = (s * PROD_W'(m_inc)) >> FRAC_W;
          res.scase = SC_AGREE;
        end else begin
          s = (s * PROD_W'(m_dec)) >> FRAC_W;
          res.scase = SC_FLIP;
        end
      end
      // The cap applies even when the step was not scaled.
      if (s > PROD_W'(m_step_max)) s = PROD_W'(m_step_max);
      res.step = s[STEP_W-1:0];
      nv = {{2{r.wval[VAL_W-1]}}, r.wval};
      if (gs == SGN_POS) nv = nv + $signed({3'b000, res.step});
      else if (gs == SGN_NEG) nv = nv - $signed({3'b000, res.step});
      if (nv > VAL_HI) res.value = 32'h7FFF_FFFF;
      else if (nv < VAL_LO) res.value = 32'h8000_0000;
      else res.value = nv[VAL_W-1:0];
      if (!r.enabled) res.value = '0;
      step_mem[r.idx] = res.step;
      sign_mem[r.idx] = gs;
    end
    return res;
  endfunction

  function automatic void add_req(input logic cmd, input int idx, input logic [31:0] grad,
                                  input logic [31:0] wval, input logic is_bias,
                                  input logic frozen, input logic enabled);
    param_req_t r;
    r = '{cmd, IN_IDX_W'(idx), grad, wval, is_bias, frozen, enabled};
    if (cmd == CMD_INIT) entry_ready[idx] = 1'b1;
    req_backlog.push_back(r);
  endfunction

  function automatic void add_random();
    int          idx;
    logic [31:0] g;
    logic [31:0] w;
    // Mostly a small working set, so sign histories build up on the same entries.
    idx = ($urandom_range(99) < 65) ? $urandom_range(15) : $urandom_range(NUM_PARAMS - 1);
    w = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(255)
                                                      : 32'h8000_0000 + $urandom_range(255))
                                 : $urandom;
    if (!entry_ready[idx] || $urandom_range(99) < 6) begin
      add_req(CMD_INIT, idx, $urandom, w, 1'($urandom_range(1)), 1'($urandom_range(1)),
              1'($urandom_range(1)));
      return;
    end
    case ($urandom_range(9))
      0:       g = '0;
      1:       g = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2, 3:    g = $urandom;
      default: begin
        g = $urandom_range(32'h000F_FFFF, 1);
        if ($urandom_range(1)) g = -g;
      end
    endcase
    add_req(CMD_UPDATE, idx, g, w, 1'($urandom_range(1)), $urandom_range(99) < 15,
            $urandom_range(99) >= 15);
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [STEP_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_INC_FACTOR: m_inc = data[FAC_W-1:0];
      CFG_DEC_FACTOR: m_dec = data[FAC_W-1:0];
      CFG_STEP_MAX:   m_step_max = data;
      CFG_STEP_INIT:  m_step_init = data;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [FAC_W-1:0] inc, input logic [FAC_W-1:0] dec,
                            input logic [STEP_W-1:0] smax, input logic [STEP_W-1:0] sinit);
    cfg_write(CFG_INC_FACTOR, STEP_W'(inc));
    cfg_write(CFG_DEC_FACTOR, STEP_W'(dec));
    cfg_write(CFG_STEP_MAX, smax);
    cfg_write(CFG_STEP_INIT, sinit);
  endtask

  // Wait until every queued request has been taken and every result checked.
  task automatic drain();
    do @(negedge clk);
    while (req_backlog.size() != 0 || in_valid || results_due.size() != 0);
    repeat (5) @(posedge clk);
    n_phases++;
  endtask

  // Driver: predicts each request as it is taken, then offers the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        results_due.push_back(rprop_predict(cur_req));
        n_sent <= n_sent + 1;
      end
      if (req_backlog.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        cur_req         = req_backlog.pop_front();
        in_cmd          <= cur_req.cmd;
        in_param_index  <= cur_req.idx;
        in_gradient     <= cur_req.grad;
        in_weight_value <= cur_req.wval;
        in_is_bias      <= cur_req.is_bias;
        in_frozen       <= cur_req.frozen;
        in_enabled      <= cur_req.enabled;
        in_valid        <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result and drives the receiver's stall.
  always @(posedge clk) begin : monitor
    param_res_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (results_due.size() == 0) begin
          flag_error("result arrived with none expected");
        end else begin
          e = results_due.pop_front();
          if (out_new_value !== e.value)
            flag_error($sformatf("new_value %0h, expected %0h", out_new_value, e.value));
          if (out_step_size !== e.step)
            flag_error($sformatf("step_size %0h, expected %0h", out_step_size, e.step));
          if (out_sign_case !== e.scase)
            flag_error($sformatf("sign_case %0d, expected %s", out_sign_case, e.scase.name()));
          case (e.scase)
            SC_AGREE: n_agree++;
            SC_FLIP:  n_flip++;
            default:  n_zero++;
          endcase
        end
      end
      out_stall <= hold_on || (!calm && $urandom_range(99) < IDLE_PCT);
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests under the reset settings.
    add_req(CMD_INIT, 0, 32'h0, 32'h0, 1'b0, 1'b0, 1'b1);
    add_req(CMD_INIT, 4095, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1, 1'b0);
    add_req(CMD_INIT, 1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b1);
    add_req(CMD_UPDATE, 0, 32'h0001_0000, 32'h0, 1'b0, 1'b0, 1'b1);
    add_req(CMD_UPDATE, 0, 32'h7FFF_FFFF, 32'h0001_0000, 1'b0, 1'b0, 1'b1);
    add_req(CMD_UPDATE, 0, 32'h8000_0000, 32'h0002_0000, 1'b0, 1'b0, 1'b1);
    add_req(CMD_UPDATE, 0, 32'h0, 32'hFFFF_0000, 1'b0, 1'b0, 1'b1);
    add_req(CMD_UPDATE, 0, 32'hFFFF_FFFF, 32'h1234_5678, 1'b0, 1'b0, 1'b1);
    add_req(CMD_UPDATE, 4095, 32'h1, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b1);
    add_req(CMD_UPDATE, 4095, 32'hFFFF_FFFB, 32'h8000_0000, 1'b1, 1'b0, 1'b1);
    add_req(CMD_UPDATE, 1, 32'h3, 32'h0000_04D2, 1'b0, 1'b0, 1'b0);
    add_req(CMD_UPDATE, 1, 32'h3, 32'h0000_162E, 1'b0, 1'b1, 1'b0);
    add_req(CMD_UPDATE, 1, 32'hFFFF_FFFD, 32'h0000_162E, 1'b1, 1'b1, 1'b0);
    add_req(CMD_UPDATE, 1, 32'hFFFF_FFFD, 32'h0000_002A, 1'b1, 1'b1, 1'b1);
    add_req(CMD_UPDATE, 1, 32'hFFFF_FFFD, 32'h0000_002A, 1'b1, 1'b0, 1'b0);
    add_req(CMD_INIT, 1, 32'h5, 32'hDEAD_BEEF, 1'b1, 1'b1, 1'b0);
    // Consecutive hits on one entry exercise the state bypass.
    add_req(CMD_INIT, 2, 32'h0, 32'h0, 1'b0, 1'b0, 1'b1);
    add_req(CMD_UPDATE, 2, 32'h0000_8000, 32'h0, 1'b0, 1'b0, 1'b1);
    add_req(CMD_UPDATE, 2, 32'h0000_8000, 32'h0, 1'b0, 1'b0, 1'b1);
    add_req(CMD_UPDATE, 2, 32'h0000_8000, 32'h0, 1'b0, 1'b0, 1'b1);
    add_req(CMD_UPDATE, 2, 32'hFFFF_8000, 32'h0, 1'b0, 1'b0, 1'b1);
    add_req(CMD_UPDATE, 2, 32'h0000_0001, 32'h0, 1'b0, 1'b1, 1'b1);
    repeat (100) add_random();
    drain();

    // Fastest growth, sign flips zero the step, widest cap, large initial step.
    set_config(16'hFFFF, 16'h0000, 31'h7FFF_FFFF, 31'h4000_0000);
    repeat (150) add_random();
    drain();

    // Zero cap with the largest initial step: every update clamps the step to zero.
    set_config(16'h0000, 16'hFFFF, 31'h0000_0000, 31'h7FFF_FFFF);
    repeat (150) add_random();
    drain();

    set_config(FAC_W'($urandom_range(65535)), FAC_W'($urandom_range(65535)),
               STEP_W'($urandom & 32'h7FFF_FFFF), STEP_W'($urandom & 32'h00FF_FFFF));
    repeat (150) add_random();
    drain();

    set_config(INC_RESET, DEC_RESET, STEP_MAX_RESET, STEP_INIT_RESET);
    repeat (150) add_random();
    drain();

    $display("Checked %0d results over %0d register settings: %0d agreeing, %0d flipped,",
             n_results, n_phases, n_agree, n_flip);
    $display("%0d with zero product, init or frozen; %0d errors.", n_zero, n_errors);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/rwu_pkg.sv
rtl/rwu_ram.sv
rtl/rwu_front.sv
rtl/rwu_queue.sv
rtl/rwu_back.sv
rtl/rprop_weight_update.sv
tb/tb_rprop_weight_update.sv
